@@ src/crt_pkg.sv @@
package crt_pkg;

  typedef enum logic [1:0] {
    ReasonBadIndex = 2'd0,
    ReasonOverflow = 2'd1,
    ReasonMetadata = 2'd2,
    ReasonTimeout  = 2'd3
  } crt_reason_e;

  localparam logic ResultText  = 1'b0;
  localparam logic ResultAbort = 1'b1;

  localparam logic [1:0] CfgTimeout  = 2'd0;
  localparam logic [1:0] CfgEvtKind  = 2'd1;
  localparam logic [1:0] CfgUnkAttr  = 2'd2;

  typedef struct packed {
    logic        we;
    logic [7:0]  be;
    logic [63:0] wdata;
  } crt_mem_req_t;

endpackage

@@ src/crt_text_store.sv @@
module crt_text_store
  import crt_pkg::*;
#(
  parameter int AW = 6
) (
  input  logic          clk_i,
  input  crt_mem_req_t  req_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [AW-1:0] raddr_i,
  output logic [63:0]   rdata_o
);

  logic [63:0] mem [2**AW];
  logic [63:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      for (int b = 0; b < 8; b++) begin
        if (req_i.be[b]) begin
          mem[waddr_i][8*b +: 8] <= req_i.wdata[8*b +: 8];
        end
      end
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/chunk_reassembly_table.sv @@
// Chunk reassembly table. Start an item with start while busy is low; busy stays high
// until the item is done. A chunk that fails the checks is answered with an abort and
// the table returns to idle. A chunk for an open transfer passes the checks, the slot
// visits of the transfer-id search, the metadata compare, one text store write, or two
// when the payload straddles a word, and the completion test. A chunk that opens a
// transfer searches every slot and then clears each 8-byte word of its text buffer.
// A completed transfer drains its text words one by one, each through a read state
// and an output state, since every word is read through the registered port of the
// text store. A tick visits the slots in order and stops at the first timed-out one.
// Results appear for exactly one cycle with result_valid_o and cannot be stalled, so the
// receiver must take every beat when it is shown; last_o marks the final beat of an item.
module chunk_reassembly_table
  import crt_pkg::*;
#(
  parameter int SLOT_COUNT     = 4,
  parameter int MAX_CHUNKS     = 16,
  parameter int PAYLOAD_BYTES  = 8,
  parameter int MAX_TEXT_BYTES = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        req_type_i,
  input  logic [31:0] xfer_id_i,
  input  logic [31:0] sess_id_i,
  input  logic [31:0] page_id_i,
  input  logic [31:0] elem_id_i,
  input  logic [7:0]  attribute_i,
  input  logic [7:0]  kind_i,
  input  logic [31:0] req_id_i,
  input  logic [7:0]  num_chunks_i,
  input  logic [7:0]  chunk_pos_i,
  input  logic [7:0]  data_size_i,
  input  logic [63:0] data_word_i,
  output logic        result_valid_o,
  output logic        result_type_o,
  output logic [31:0] out_xfer_id_o,
  output logic [31:0] out_sess_id_o,
  output logic [31:0] out_page_id_o,
  output logic [31:0] out_elem_id_o,
  output logic [7:0]  out_attribute_o,
  output logic [7:0]  out_kind_o,
  output logic [31:0] out_req_id_o,
  output logic [1:0]  abort_reason_o,
  output logic [63:0] text_word_o,
  output logic [3:0]  byte_count_o,
  output logic        last_o
);

  localparam int SW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW    = $clog2(MAX_CHUNKS + 1);
  localparam int IW    = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int LW    = $clog2(MAX_TEXT_BYTES + 1);
  localparam int WORDS = (MAX_TEXT_BYTES + 7) / 8;
  localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int AW    = SW + WW;
  localparam int DW    = LW + WW + 4;

  typedef enum logic [3:0] {
    StIdle, StCheck, StMatch, StMeta, StClear, StWrLo, StWrHi, StFin, StDrd, StDout, StTick
  } state_e;

  state_e state_q;

  logic [31:0] timeout_q;
  logic [7:0]  evt_kind_q, unk_attr_q;
  logic [31:0] time_q;

  logic [31:0] tid_q, ses_q, pag_q, ele_q, rid_q;
  logic [7:0]  att_q, knd_q, cnt_q, idx_q, dsz_q;
  logic [63:0] data_q;

  logic            used_q  [SLOT_COUNT];
  logic [31:0]     s_tid_q [SLOT_COUNT];
  logic [31:0]     s_ses_q [SLOT_COUNT];
  logic [31:0]     s_pag_q [SLOT_COUNT];
  logic [31:0]     s_ele_q [SLOT_COUNT];
  logic [7:0]      s_att_q [SLOT_COUNT];
  logic [7:0]      s_knd_q [SLOT_COUNT];
  logic [31:0]     s_rid_q [SLOT_COUNT];
  logic [CW-1:0]   s_tot_q [SLOT_COUNT];
  logic [MAX_CHUNKS-1:0] s_map_q [SLOT_COUNT];
  logic [CW-1:0]   s_rcv_q [SLOT_COUNT];
  logic [LW-1:0]   s_len_q [SLOT_COUNT];
  logic [31:0]     s_last_q [SLOT_COUNT];

  logic [SW-1:0] ptr_q, free_q;
  logic          free_found_q;
  logic [WW-1:0] wcnt_q;

  logic          res_valid_q, res_type_q, res_last_q;
  logic [31:0]   res_tid_q, res_ses_q, res_pag_q, res_ele_q, res_rid_q;
  logic [7:0]    res_att_q, res_knd_q;
  logic [1:0]    res_reason_q;
  logic [63:0]   res_word_q;
  logic [3:0]    res_n_q;

  logic bad_idx, oversize, evt_attr, hit, cur_free, meta_bad, timed_out, at_end;
  logic [LW-1:0]  off, chunk_end;
  logic [WW-1:0]  wlo;
  logic [2:0]     sh;
  logic [127:0]   wide;
  logic [15:0]    be16;
  logic [7:0]     mask8;
  logic [WW:0]    nwords;
  logic [DW-1:0]  rem;
  logic [3:0]     nbytes;
  logic [63:0]    rdata, masked;
  crt_mem_req_t   mreq;
  logic [AW-1:0]  waddr;
  logic [SW-1:0]  sel_free;

  assign busy = (state_q != StIdle);

  always_comb begin
    bad_idx  = (tid_q == 32'd0) || (cnt_q == 8'd0) || (9'(cnt_q) > 9'(MAX_CHUNKS)) ||
               (idx_q >= cnt_q);
    oversize = (dsz_q > 8'(PAYLOAD_BYTES)) ||
               ((16'(cnt_q) * 16'(PAYLOAD_BYTES)) > 16'(MAX_TEXT_BYTES));
    evt_attr = (knd_q == evt_kind_q) && (att_q != unk_attr_q);
    hit      = used_q[ptr_q] && (s_tid_q[ptr_q] == tid_q);
    cur_free = !used_q[ptr_q];
    sel_free = free_found_q ? free_q : ptr_q;
    at_end   = (32'(ptr_q) == 32'(SLOT_COUNT - 1));
    meta_bad = (s_ses_q[ptr_q] != ses_q) || (s_pag_q[ptr_q] != pag_q) ||
               (s_ele_q[ptr_q] != ele_q) || (s_att_q[ptr_q] != att_q) ||
               (s_knd_q[ptr_q] != knd_q) || (s_rid_q[ptr_q] != rid_q) ||
               (s_tot_q[ptr_q] != CW'(cnt_q));
    timed_out = used_q[ptr_q] && ((time_q - s_last_q[ptr_q]) >= timeout_q);

    off       = LW'(16'(idx_q[IW-1:0]) * 16'(PAYLOAD_BYTES));
    chunk_end = off + LW'(dsz_q[3:0]);
    wlo       = WW'(off >> 3);
    sh        = off[2:0];
    wide      = {64'd0, data_q} << {sh, 3'b000};
    mask8     = 8'((9'd1 << dsz_q[3:0]) - 9'd1);
    be16      = {8'd0, mask8} << sh;

    nwords = (s_len_q[ptr_q] == '0) ? (WW+1)'(1) :
             (WW+1)'((DW'(s_len_q[ptr_q]) + DW'(7)) >> 3);
    if (DW'(s_len_q[ptr_q]) > (DW'(wcnt_q) << 3)) begin
      rem = DW'(s_len_q[ptr_q]) - (DW'(wcnt_q) << 3);
    end else begin
      rem = '0;
    end
    nbytes = (rem > DW'(8)) ? 4'd8 : 4'(rem);
    for (int b = 0; b < 8; b++) begin
      masked[8*b +: 8] = (4'(b) < nbytes) ? rdata[8*b +: 8] : 8'd0;
    end

    mreq  = '0;
    waddr = {ptr_q, wcnt_q};
    case (state_q)
      StClear: begin
        mreq.we = 1'b1;
        mreq.be = 8'hff;
      end
      StWrLo: begin
        mreq.we    = 1'b1;
        mreq.be    = be16[7:0];
        mreq.wdata = wide[63:0];
        waddr      = {ptr_q, wlo};
      end
      StWrHi: begin
        mreq.we    = 1'b1;
        mreq.be    = be16[15:8];
        mreq.wdata = wide[127:64];
        waddr      = {ptr_q, WW'(wlo + WW'(1))};
      end
      default: ;
    endcase
  end

  crt_text_store #(.AW(AW)) u_store (
    .clk_i   (clk_i),
    .req_i   (mreq),
    .waddr_i (waddr),
    .raddr_i ({ptr_q, wcnt_q}),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      timeout_q    <= 32'd1000;
      evt_kind_q   <= 8'd1;
      unk_attr_q   <= 8'd0;
      time_q       <= '0;
      ptr_q        <= '0;
      free_q       <= '0;
      free_found_q <= 1'b0;
      wcnt_q       <= '0;
      res_valid_q  <= 1'b0;
      for (int s = 0; s < SLOT_COUNT; s++) begin
        used_q[s] <= 1'b0;
      end
    end else begin
      res_valid_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgTimeout: timeout_q  <= cfg_data_i;
          CfgEvtKind: evt_kind_q <= cfg_data_i[7:0];
          CfgUnkAttr: unk_attr_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      case (state_q)
        StIdle: begin
          if (start) begin
            tid_q  <= xfer_id_i;
            ses_q  <= sess_id_i;
            pag_q  <= page_id_i;
            ele_q  <= elem_id_i;
            att_q  <= attribute_i;
            knd_q  <= kind_i;
            rid_q  <= req_id_i;
            cnt_q  <= num_chunks_i;
            idx_q  <= chunk_pos_i;
            dsz_q  <= data_size_i;
            data_q <= data_word_i;
            ptr_q        <= '0;
            free_found_q <= 1'b0;
            if (req_type_i) begin
              time_q  <= time_q + 32'd1;
              state_q <= StTick;
            end else begin
              state_q <= StCheck;
            end
          end
        end
        StCheck: begin
          res_type_q <= ResultAbort;
          res_tid_q  <= tid_q;
          res_rid_q  <= rid_q;
          res_ses_q  <= '0;
          res_pag_q  <= '0;
          res_ele_q  <= '0;
          res_att_q  <= '0;
          res_knd_q  <= '0;
          res_word_q <= '0;
          res_n_q    <= '0;
          res_last_q <= 1'b1;
          if (bad_idx) begin
            res_valid_q  <= 1'b1;
            res_reason_q <= ReasonBadIndex;
            state_q      <= StIdle;
          end else if (oversize) begin
            res_valid_q  <= 1'b1;
            res_reason_q <= ReasonOverflow;
            state_q      <= StIdle;
          end else if (evt_attr) begin
            res_valid_q  <= 1'b1;
            res_reason_q <= ReasonMetadata;
            state_q      <= StIdle;
          end else begin
            state_q <= StMatch;
          end
        end
        StMatch: begin
          if (hit) begin
            state_q <= StMeta;
          end else if (!at_end) begin
            if (cur_free && !free_found_q) begin
              free_q       <= ptr_q;
              free_found_q <= 1'b1;
            end
            ptr_q <= ptr_q + SW'(1);
          end else if (free_found_q || cur_free) begin
            ptr_q             <= sel_free;
            used_q[sel_free]  <= 1'b1;
            s_tid_q[sel_free] <= tid_q;
            s_ses_q[sel_free] <= ses_q;
            s_pag_q[sel_free] <= pag_q;
            s_ele_q[sel_free] <= ele_q;
            s_att_q[sel_free] <= att_q;
            s_knd_q[sel_free] <= knd_q;
            s_rid_q[sel_free] <= rid_q;
            s_tot_q[sel_free] <= CW'(cnt_q);
            s_map_q[sel_free] <= '0;
            s_rcv_q[sel_free] <= '0;
            s_len_q[sel_free] <= '0;
            wcnt_q            <= '0;
            state_q           <= StClear;
          end else begin
            res_valid_q  <= 1'b1;
            res_reason_q <= ReasonOverflow;
            state_q      <= StIdle;
          end
        end
        StMeta: begin
          if (meta_bad) begin
            res_valid_q    <= 1'b1;
            res_reason_q   <= ReasonMetadata;
            res_tid_q      <= s_tid_q[ptr_q];
            res_rid_q      <= s_rid_q[ptr_q];
            used_q[ptr_q]  <= 1'b0;
            state_q        <= StIdle;
          end else begin
            state_q <= StWrLo;
          end
        end
        StClear: begin
          if (32'(wcnt_q) == 32'(WORDS - 1)) begin
            state_q <= StWrLo;
          end
          wcnt_q <= wcnt_q + WW'(1);
        end
        StWrLo: begin
          if (!s_map_q[ptr_q][idx_q[IW-1:0]]) begin
            s_map_q[ptr_q][idx_q[IW-1:0]] <= 1'b1;
            s_rcv_q[ptr_q] <= s_rcv_q[ptr_q] + CW'(1);
          end
          if (chunk_end > s_len_q[ptr_q]) begin
            s_len_q[ptr_q] <= chunk_end;
          end
          s_last_q[ptr_q] <= time_q;
          state_q <= (|be16[15:8]) ? StWrHi : StFin;
        end
        StWrHi: begin
          state_q <= StFin;
        end
        StFin: begin
          wcnt_q <= '0;
          if (s_rcv_q[ptr_q] == s_tot_q[ptr_q]) begin
            state_q <= StDrd;
          end else begin
            state_q <= StIdle;
          end
        end
        StDrd: begin
          state_q <= StDout;
        end
        StDout: begin
          res_valid_q  <= 1'b1;
          res_type_q   <= ResultText;
          res_tid_q    <= s_tid_q[ptr_q];
          res_ses_q    <= s_ses_q[ptr_q];
          res_pag_q    <= s_pag_q[ptr_q];
          res_ele_q    <= s_ele_q[ptr_q];
          res_att_q    <= s_att_q[ptr_q];
          res_knd_q    <= s_knd_q[ptr_q];
          res_rid_q    <= s_rid_q[ptr_q];
          res_reason_q <= '0;
          res_word_q   <= masked;
          res_n_q      <= nbytes;
          if ((WW+1)'(wcnt_q) + (WW+1)'(1) == nwords) begin
            res_last_q    <= 1'b1;
            used_q[ptr_q] <= 1'b0;
            state_q       <= StIdle;
          end else begin
            res_last_q <= 1'b0;
            wcnt_q     <= wcnt_q + WW'(1);
            state_q    <= StDrd;
          end
        end
        StTick: begin
          if (timed_out) begin
            res_valid_q   <= 1'b1;
            res_type_q    <= ResultAbort;
            res_tid_q     <= s_tid_q[ptr_q];
            res_rid_q     <= s_rid_q[ptr_q];
            res_ses_q     <= '0;
            res_pag_q     <= '0;
            res_ele_q     <= '0;
            res_att_q     <= '0;
            res_knd_q     <= '0;
            res_word_q    <= '0;
            res_n_q       <= '0;
            res_last_q    <= 1'b1;
            res_reason_q  <= ReasonTimeout;
            used_q[ptr_q] <= 1'b0;
            state_q       <= StIdle;
          end else if (at_end) begin
            state_q <= StIdle;
          end else begin
            ptr_q <= ptr_q + SW'(1);
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign result_valid_o   = res_valid_q;
  assign result_type_o    = res_type_q;
  assign out_xfer_id_o    = res_tid_q;
  assign out_sess_id_o    = res_ses_q;
  assign out_page_id_o    = res_pag_q;
  assign out_elem_id_o    = res_ele_q;
  assign out_attribute_o  = res_att_q;
  assign out_kind_o       = res_knd_q;
  assign out_req_id_o     = res_rid_q;
  assign abort_reason_o   = res_reason_q;
  assign text_word_o      = res_word_q;
  assign byte_count_o     = res_n_q;
  assign last_o           = res_last_q;

endmodule

@@ tb/tb_chunk_reassembly_table.sv @@
module tb_chunk_reassembly_table;
  import crt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumSlots = 4;
  localparam int ChunkMax = 16;
  localparam int BeatBytes = 8;
  localparam int TextMax = 128;
  localparam int StallLimit = 20000;

  typedef struct packed {
    logic        req_type;
    logic [31:0] xfer_id;
    logic [31:0] sess_id;
    logic [31:0] page_id;
    logic [31:0] elem_id;
    logic [7:0]  attribute;
    logic [7:0]  kind;
    logic [31:0] req_id;
    logic [7:0]  num_chunks;
    logic [7:0]  chunk_pos;
    logic [7:0]  data_size;
    logic [63:0] data_word;
  } chunk_req_t;

  typedef struct packed {
    logic        result_type;
    logic [31:0] xfer_id;
    logic [31:0] sess_id;
    logic [31:0] page_id;
    logic [31:0] elem_id;
    logic [7:0]  attribute;
    logic [7:0]  kind;
    logic [31:0] req_id;
    logic [1:0]  reason;
    logic [63:0] text_word;
    logic [3:0]  byte_count;
    logic        last;
  } text_beat_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;
  chunk_req_t  req;
  logic        result_valid_o;
  text_beat_t  rsp;

  logic        rsp_type;
  logic [31:0] rsp_xfer;
  logic [31:0] rsp_sess;
  logic [31:0] rsp_page;
  logic [31:0] rsp_elem;
  logic [7:0]  rsp_att;
  logic [7:0]  rsp_knd;
  logic [31:0] rsp_rid;
  logic [1:0]  rsp_reason;
  logic [63:0] rsp_word;
  logic [3:0]  rsp_n;
  logic        rsp_last;

  chunk_reassembly_table u_top (
    .clk_i, .rst_ni, .start, .busy, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .req_type_i(req.req_type), .xfer_id_i(req.xfer_id),
    .sess_id_i(req.sess_id), .page_id_i(req.page_id),
    .elem_id_i(req.elem_id), .attribute_i(req.attribute), .kind_i(req.kind),
    .req_id_i(req.req_id), .num_chunks_i(req.num_chunks),
    .chunk_pos_i(req.chunk_pos), .data_size_i(req.data_size),
    .data_word_i(req.data_word), .result_valid_o,
    .result_type_o(rsp_type), .out_xfer_id_o(rsp_xfer),
    .out_sess_id_o(rsp_sess), .out_page_id_o(rsp_page),
    .out_elem_id_o(rsp_elem), .out_attribute_o(rsp_att),
    .out_kind_o(rsp_knd), .out_req_id_o(rsp_rid),
    .abort_reason_o(rsp_reason), .text_word_o(rsp_word),
    .byte_count_o(rsp_n), .last_o(rsp_last)
  );

  assign rsp = {rsp_type, rsp_xfer, rsp_sess, rsp_page, rsp_elem, rsp_att, rsp_knd,
                rsp_rid, rsp_reason, rsp_word, rsp_n, rsp_last};

  // Shadow copy of the table.
  logic        sh_used [NumSlots];
  logic [31:0] sh_tid [NumSlots];
  logic [31:0] sh_ses [NumSlots];
  logic [31:0] sh_pag [NumSlots];
  logic [31:0] sh_ele [NumSlots];
  logic [7:0]  sh_att [NumSlots];
  logic [7:0]  sh_knd [NumSlots];
  logic [31:0] sh_rid [NumSlots];
  logic [7:0]  sh_total [NumSlots];
  logic [15:0] sh_map [NumSlots];
  logic [7:0]  sh_rcvd [NumSlots];
  logic [7:0]  sh_len [NumSlots];
  logic [31:0] sh_last [NumSlots];
  logic [7:0]  sh_text [NumSlots][TextMax];
  logic [31:0] now_ms;
  logic [31:0] timeout_ms;
  logic [7:0]  evt_kind;
  logic [7:0]  unk_attr;

  text_beat_t  pending_beats[$];
  int          mismatches;
  int          beats_seen;
  int          aborts_seen;
  int          idle_cycles;
  bit          allow_gaps;
  bit          timed_out;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic void drop_slot(int s);
    sh_used[s] = 1'b0; sh_tid[s] = '0; sh_ses[s] = '0; sh_pag[s] = '0;
    sh_ele[s] = '0; sh_att[s] = '0; sh_knd[s] = '0; sh_rid[s] = '0;
    sh_total[s] = '0; sh_map[s] = '0; sh_rcvd[s] = '0; sh_len[s] = '0;
    sh_last[s] = '0;
  endfunction

  function automatic void push_abort(logic [31:0] tid, logic [31:0] rid,
                                     crt_reason_e why);
    text_beat_t b;
    b = '0;
    b.result_type = ResultAbort;
    b.xfer_id = tid;
    b.req_id = rid;
    b.reason = why;
    b.last = 1'b1;
    pending_beats.push_back(b);
  endfunction

  function automatic void reassemble(chunk_req_t r);
    int slot;
    int off;
    int fin;
    int words;
    text_beat_t b;
    slot = -1;
    if (r.req_type) begin
      now_ms = now_ms + 32'd1;
      for (int s = 0; s < NumSlots; s++) begin
        if (sh_used[s] && (now_ms - sh_last[s]) >= timeout_ms) begin
          push_abort(sh_tid[s], sh_rid[s], ReasonTimeout);
          drop_slot(s);
          return;
        end
      end
      return;
    end
    if (r.xfer_id == 0 || r.num_chunks == 0 || r.num_chunks > ChunkMax ||
        r.chunk_pos >= r.num_chunks) begin
      push_abort(r.xfer_id, r.req_id, ReasonBadIndex);
      return;
    end
    if (r.data_size > BeatBytes || int'(r.num_chunks) * BeatBytes > TextMax) begin
      push_abort(r.xfer_id, r.req_id, ReasonOverflow);
      return;
    end
    if (r.kind == evt_kind && r.attribute != unk_attr) begin
      push_abort(r.xfer_id, r.req_id, ReasonMetadata);
      return;
    end
    for (int s = 0; s < NumSlots; s++)
      if (slot < 0 && sh_used[s] && sh_tid[s] == r.xfer_id) slot = s;
    if (slot < 0) begin
      for (int s = 0; s < NumSlots; s++)
        if (slot < 0 && !sh_used[s]) slot = s;
      if (slot < 0) begin
        push_abort(r.xfer_id, r.req_id, ReasonOverflow);
        return;
      end
      drop_slot(slot);
      for (int i = 0; i < TextMax; i++) sh_text[slot][i] = '0;
      sh_used[slot] = 1'b1; sh_tid[slot] = r.xfer_id;
      sh_ses[slot] = r.sess_id; sh_pag[slot] = r.page_id;
      sh_ele[slot] = r.elem_id; sh_att[slot] = r.attribute;
      sh_knd[slot] = r.kind; sh_rid[slot] = r.req_id;
      sh_total[slot] = r.num_chunks;
    end else if (sh_ses[slot] != r.sess_id || sh_pag[slot] != r.page_id ||
                 sh_ele[slot] != r.elem_id || sh_att[slot] != r.attribute ||
                 sh_knd[slot] != r.kind || sh_rid[slot] != r.req_id ||
                 sh_total[slot] != r.num_chunks) begin
      push_abort(sh_tid[slot], sh_rid[slot], ReasonMetadata);
      drop_slot(slot);
      return;
    end
    off = int'(r.chunk_pos) * BeatBytes;
    fin = off + int'(r.data_size);
    if (fin > TextMax || fin > int'(sh_total[slot]) * BeatBytes) begin
      push_abort(sh_tid[slot], sh_rid[slot], ReasonOverflow);
      drop_slot(slot);
      return;
    end
    for (int i = 0; i < int'(r.data_size); i++) sh_text[slot][off + i] = r.data_word[8*i +: 8];
    if (!sh_map[slot][r.chunk_pos[3:0]]) begin
      sh_map[slot][r.chunk_pos[3:0]] = 1'b1;
      sh_rcvd[slot] = 8'(sh_rcvd[slot] + 8'd1);
    end
    if (fin > int'(sh_len[slot])) sh_len[slot] = 8'(fin);
    sh_last[slot] = now_ms;
    if (sh_rcvd[slot] != sh_total[slot]) return;
    words = (int'(sh_len[slot]) + 7) / 8;
    if (words == 0) words = 1;
    for (int w = 0; w < words; w++) begin
      b = '0;
      b.result_type = ResultText;
      b.xfer_id = sh_tid[slot]; b.sess_id = sh_ses[slot];
      b.page_id = sh_pag[slot]; b.elem_id = sh_ele[slot];
      b.attribute = sh_att[slot]; b.kind = sh_knd[slot];
      b.req_id = sh_rid[slot];
      for (int i = 0; i < 8; i++) begin
        if (w * 8 + i < int'(sh_len[slot])) begin
          b.text_word[8*i +: 8] = sh_text[slot][w*8 + i];
          b.byte_count = 4'(b.byte_count + 4'd1);
        end
      end
      b.last = (w + 1 == words);
      pending_beats.push_back(b);
    end
    drop_slot(slot);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      text_beat_t want;
      beats_seen++;
      if (rsp.result_type == ResultAbort) aborts_seen++;
      if (pending_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected beat: %p", rsp);
      end else begin
        want = pending_beats.pop_front();
        if (rsp !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("Beat mismatch: expected %p, got %p", want, rsp);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("Watchdog expired with %0d beats pending", pending_beats.size());
      $display("[chunk_reassembly_table] ERROR");
      $finish;
    end
  end

  task automatic send_item(chunk_req_t r);
    if (allow_gaps && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 10)) @(negedge clk_i);
    @(negedge clk_i);
    req <= r;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    reassemble(r);
    @(negedge clk_i);
    start <= 1'b0;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    while (pending_beats.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgTimeout: timeout_ms = val;
      CfgEvtKind: evt_kind = val[7:0];
      CfgUnkAttr: unk_attr = val[7:0];
      default: ;
    endcase
  endtask

  function automatic chunk_req_t make_chunk(logic [31:0] tid, logic [7:0] cnt,
                                            logic [7:0] idx, logic [7:0] size);
    chunk_req_t r;
    r = '0;
    r.xfer_id = tid;
    r.sess_id = tid ^ 32'h5a5a_0001;
    r.page_id = tid + 32'd7;
    r.elem_id = ~tid;
    r.attribute = unk_attr;
    r.kind = evt_kind;
    r.req_id = 32'(tid * 32'd3);
    r.num_chunks = cnt;
    r.chunk_pos = idx;
    r.data_size = size;
    r.data_word = {$urandom, $urandom};
    return r;
  endfunction

  task automatic send_tick();
    chunk_req_t r;
    r = '0;
    r.req_type = 1'b1;
    r.xfer_id = $urandom;
    r.data_word = {$urandom, $urandom};
    send_item(r);
  endtask

  task automatic test_directed();
    chunk_req_t r;
    send_item(make_chunk(32'd0, 8'd2, 8'd0, 8'd8));
    send_item(make_chunk(32'd5, 8'd0, 8'd0, 8'd8));
    send_item(make_chunk(32'd5, 8'd17, 8'd0, 8'd8));
    send_item(make_chunk(32'd5, 8'd3, 8'd3, 8'd8));
    send_item(make_chunk(32'd5, 8'd2, 8'd0, 8'd9));
    send_item(make_chunk(32'd5, 8'd2, 8'd0, 8'd255));
    r = make_chunk(32'd5, 8'd2, 8'd0, 8'd4);
    r.attribute = 8'hff;
    send_item(r);
    send_item(make_chunk(32'hffff_ffff, 8'd1, 8'd0, 8'd0));
    send_item(make_chunk(32'd9, 8'd16, 8'd15, 8'd8));
    for (int i = 0; i < 16; i++) send_item(make_chunk(32'd9, 8'd16, 8'(i), 8'd8));
    send_item(make_chunk(32'd11, 8'd2, 8'd1, 8'd3));
    send_item(make_chunk(32'd11, 8'd2, 8'd1, 8'd5));
    r = make_chunk(32'd11, 8'd2, 8'd0, 8'd8);
    r.page_id = '0;
    send_item(r);
  endtask

  task automatic test_table_full();
    for (int t = 1; t <= 5; t++) send_item(make_chunk(32'(100 + t), 8'd2, 8'd0, 8'd8));
    for (int t = 1; t <= 4; t++) send_item(make_chunk(32'(100 + t), 8'd2, 8'd1, 8'd2));
  endtask

  task automatic test_timeouts();
    write_reg(CfgTimeout, 32'd3);
    send_item(make_chunk(32'd200, 8'd4, 8'd0, 8'd8));
    send_item(make_chunk(32'd201, 8'd4, 8'd0, 8'd8));
    repeat (8) send_tick();
    write_reg(CfgTimeout, 32'd0);
    send_item(make_chunk(32'd202, 8'd4, 8'd0, 8'd8));
    send_tick();
    send_tick();
    write_reg(CfgTimeout, 32'hffff_ffff);
    send_item(make_chunk(32'd203, 8'd4, 8'd0, 8'd8));
    repeat (3) send_tick();
    send_item(make_chunk(32'd203, 8'd4, 8'd1, 8'd8));
  endtask

  task automatic test_random(int n, bit gaps);
    chunk_req_t r;
    logic [31:0] tid;
    int cnt;
    allow_gaps = gaps;
    for (int k = 0; k < n; ) begin
      case ($urandom_range(0, 9))
        0: begin
          r = '0;
          r.xfer_id = $urandom;
          r.sess_id = $urandom;
          r.page_id = $urandom;
          r.elem_id = $urandom;
          r.attribute = 8'($urandom);
          r.kind = 8'($urandom);
          r.req_id = $urandom;
          r.num_chunks = 8'($urandom);
          r.chunk_pos = 8'($urandom);
          r.data_size = 8'($urandom);
          r.data_word = {$urandom, $urandom};
          send_item(r);
          k++;
        end
        1: begin
          send_tick();
          k++;
        end
        default: begin
          tid = $urandom_range(1, 3) == 1 ? $urandom : $urandom_range(1, 6);
          cnt = $urandom_range(0, 3) == 0 ? ChunkMax : $urandom_range(1, 4);
          for (int c = 0; c < cnt; c++) begin
            r = make_chunk(tid, 8'(cnt), 8'($urandom_range(0, cnt - 1)),
                           8'($urandom_range(0, 8)));
            if ($urandom_range(0, 2) != 0) r.chunk_pos = 8'(c);
            if ($urandom_range(0, 30) == 0) r.sess_id = $urandom;
            send_item(r);
            k++;
          end
        end
      endcase
    end
  endtask

  task automatic test_config_sweep();
    write_reg(CfgEvtKind, 32'h0000_00ff);
    write_reg(CfgUnkAttr, 32'h0000_00ff);
    test_random(35, 1'b1);
    write_reg(CfgEvtKind, 32'h0000_0000);
    write_reg(CfgUnkAttr, 32'h0000_003c);
    write_reg(CfgTimeout, 32'd2);
    test_random(35, 1'b1);
    write_reg(CfgTimeout, 32'd1000);
    write_reg(CfgEvtKind, 32'd1);
    write_reg(CfgUnkAttr, 32'd0);
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    req = '0;
    mismatches = 0;
    beats_seen = 0;
    aborts_seen = 0;
    idle_cycles = 0;
    allow_gaps = 1'b0;
    timed_out = 1'b0;
    for (int s = 0; s < NumSlots; s++) begin
      drop_slot(s);
      for (int i = 0; i < TextMax; i++) sh_text[s][i] = '0;
    end
    now_ms = '0;
    timeout_ms = 32'd1000;
    evt_kind = 8'd1;
    unk_attr = 8'd0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_table_full();
    test_timeouts();
    test_random(45, 1'b1);
    test_config_sweep();
    test_random(30, 1'b0);
    while (pending_beats.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    $display("Covered all validation aborts, full table, timeouts and full-length transfers.");
    $display("Checked %0d result beats, %0d of them abort notices.", beats_seen, aborts_seen);
    if (mismatches == 0 && pending_beats.size() == 0) begin
      $display("[chunk_reassembly_table] OK");
    end else begin
      $display("[chunk_reassembly_table] ERROR");
    end
    $finish;
  end

endmodule
